// File: sv/triangle_channel_funnel_path_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef TRIANGLE_CHANNEL_FUNNEL_PATH_ASSERT_SVH
`define TRIANGLE_CHANNEL_FUNNEL_PATH_ASSERT_SVH

// Next-cycle implication, ignored while reset is asserted.
`define TCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TCFP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tcfp_pkg.sv
package tcfp_pkg;

  localparam int COORD_W   = 24;
  localparam int ID_W      = 16;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 50;
  localparam int CROSS_W   = 51;
  localparam int NUM_CROSS = 5;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_PORTAL,
    KIND_DROP
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X,
    CFG_START_Y,
    CFG_END_X,
    CFG_END_Y
  } cfg_idx_t;

  // One classified triangle as it travels from the front to the back.
  typedef struct packed {
    kind_t            kind;
    logic [1:0]       u;
    logic [ID_W-1:0]  e0_id;
    logic [ID_W-1:0]  e1_id;
    point_t           p0;
    point_t           p1;
    point_t           p2;
    logic             last;
    logic             ovf;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] n;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_STORE,
    ST_START,
    ST_READ,
    ST_MUL,
    ST_DEC,
    ST_END
  } back_state_t;

endpackage

// File: sv/tcfp_if.sv
interface tcfp_in_if;
  logic                              valid;
  logic                              ready;
  logic [tcfp_pkg::ID_W-1:0]         apex0_id;
  logic [tcfp_pkg::ID_W-1:0]         apex1_id;
  logic [tcfp_pkg::ID_W-1:0]         apex2_id;
  logic signed [tcfp_pkg::COORD_W-1:0] apex0_x;
  logic signed [tcfp_pkg::COORD_W-1:0] apex0_y;
  logic signed [tcfp_pkg::COORD_W-1:0] apex1_x;
  logic signed [tcfp_pkg::COORD_W-1:0] apex1_y;
  logic signed [tcfp_pkg::COORD_W-1:0] apex2_x;
  logic signed [tcfp_pkg::COORD_W-1:0] apex2_y;
  logic                              last_triangle;

  modport source (output valid, apex0_id, apex1_id, apex2_id, apex0_x, apex0_y,
                  apex1_x, apex1_y, apex2_x, apex2_y, last_triangle, input ready);
  modport sink (input valid, apex0_id, apex1_id, apex2_id, apex0_x, apex0_y,
                apex1_x, apex1_y, apex2_x, apex2_y, last_triangle, output ready);
endinterface

interface tcfp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tcfp_pkg::COORD_W-1:0] waypoint_x;
  logic signed [tcfp_pkg::COORD_W-1:0] waypoint_y;
  logic                                last_point;
  logic                                overflow;

  modport source (output valid, waypoint_x, waypoint_y, last_point, overflow,
                  input ready);
  modport sink (input valid, waypoint_x, waypoint_y, last_point, overflow,
                output ready);
endinterface

// File: sv/tcfp_queue.sv
module tcfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  tcfp_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output tcfp_pkg::item_t pop_item,
  input  logic            pop_ready
);

  tcfp_pkg::item_t store_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      fill_r;
  logic            do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_item   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) fill_r <= fill_r + 2'd1;
      else if (do_pop && !do_push) fill_r <= fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: sv/tcfp_front.sv
module tcfp_front #(
  parameter int MAX_TRIANGLES  = 32,
  parameter int VERTEX_ID_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  tcfp_in_if.sink         in_ch,
  output logic            push_valid,
  output tcfp_pkg::item_t push_item,
  input  logic            push_ready
);

  localparam logic [tcfp_pkg::ID_W-1:0] ID_MASK = (VERTEX_ID_BITS >= tcfp_pkg::ID_W) ?
      {tcfp_pkg::ID_W{1'b1}} : tcfp_pkg::ID_W'((64'd1 << VERTEX_ID_BITS) - 64'd1);
  localparam logic [tcfp_pkg::CNT_W-1:0] MAXC = tcfp_pkg::CNT_W'(MAX_TRIANGLES);

  logic [tcfp_pkg::ID_W-1:0]  prev_ids_r [3];
  logic [tcfp_pkg::ID_W-1:0]  ids [3];
  logic [tcfp_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [2:0]                 found;
  logic [1:0]                 u, c0, c1;
  logic                       accept;
  tcfp_pkg::kind_t            kind;

  assign ids[0] = in_ch.apex0_id & ID_MASK;
  assign ids[1] = in_ch.apex1_id & ID_MASK;
  assign ids[2] = in_ch.apex2_id & ID_MASK;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  // The unshared corner of the previous triangle is the first one whose id is missing.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      found[c] = (prev_ids_r[c] == ids[0]) || (prev_ids_r[c] == ids[1]) ||
                 (prev_ids_r[c] == ids[2]);
    end
    if (!found[0]) u = 2'd0;
    else if (!found[1]) u = 2'd1;
    else u = 2'd2;
    c0 = (u == 2'd0) ? 2'd1 : 2'd0;
    c1 = (u == 2'd2) ? 2'd1 : 2'd2;

    if (count_r == '0) kind = tcfp_pkg::KIND_FIRST;
    else if (count_r < MAXC) kind = tcfp_pkg::KIND_PORTAL;
    else kind = tcfp_pkg::KIND_DROP;

    push_item.kind  = kind;
    push_item.u     = u;
    push_item.e0_id = prev_ids_r[c0];
    push_item.e1_id = prev_ids_r[c1];
    push_item.p0    = '{x: in_ch.apex0_x, y: in_ch.apex0_y};
    push_item.p1    = '{x: in_ch.apex1_x, y: in_ch.apex1_y};
    push_item.p2    = '{x: in_ch.apex2_x, y: in_ch.apex2_y};
    push_item.last  = in_ch.last_triangle;
    push_item.ovf   = ovf_r || (kind == tcfp_pkg::KIND_DROP);
    push_item.idx   = count_r;
    push_item.n     = (kind == tcfp_pkg::KIND_DROP) ? count_r : count_r + 1'b1;

    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_ch.last_triangle) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        ovf_nxt = push_item.ovf;
        if (kind != tcfp_pkg::KIND_DROP) count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      for (int c = 0; c < 3; c++) prev_ids_r[c] <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (accept) begin
        for (int c = 0; c < 3; c++) begin
          if (in_ch.last_triangle) prev_ids_r[c] <= '0;
          else if (kind != tcfp_pkg::KIND_DROP) prev_ids_r[c] <= ids[c];
        end
      end
    end
  end

endmodule

// File: sv/tcfp_back.sv
module tcfp_back #(
  parameter int MAX_TRIANGLES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  tcfp_pkg::item_t  pop_item,
  output logic             pop_ready,
  input  tcfp_pkg::point_t start_pt,
  input  tcfp_pkg::point_t end_pt,
  tcfp_out_if.source       out_ch
);

  localparam int AW = (MAX_TRIANGLES > 2) ? $clog2(MAX_TRIANGLES) : 1;
  localparam logic [tcfp_pkg::CNT_W-1:0] MAXC = tcfp_pkg::CNT_W'(MAX_TRIANGLES);

  typedef logic signed [tcfp_pkg::PROD_W-1:0]  prod_t;
  typedef logic signed [tcfp_pkg::CROSS_W-1:0] cross_t;
  typedef logic [tcfp_pkg::CNT_W-1:0]          cnt_t;

  tcfp_pkg::back_state_t state_r, state_nxt;

  tcfp_pkg::point_t mem_l [MAX_TRIANGLES];
  tcfp_pkg::point_t mem_r [MAX_TRIANGLES];
  tcfp_pkg::point_t rd_l_r, rd_r_r;

  tcfp_pkg::item_t  cur_r;
  tcfp_pkg::point_t prev_pts_r [3];
  tcfp_pkg::point_t cur_pts [3];
  logic [tcfp_pkg::ID_W-1:0] last_l_id_r, last_r_id_r;

  tcfp_pkg::point_t apex_r, lft_r, rgt_r, lpt_r, rpt_r;
  cnt_t             ai_r, li_r, ri_r, i_r, cnt_r;

  prod_t  pa_r [tcfp_pkg::NUM_CROSS];
  prod_t  pb_r [tcfp_pkg::NUM_CROSS];
  cross_t cr   [tcfp_pkg::NUM_CROSS];

  tcfp_pkg::point_t op_a;
  tcfp_pkg::point_t op_b [tcfp_pkg::NUM_CROSS];
  tcfp_pkg::point_t op_c [tcfp_pkg::NUM_CROSS];
  tcfp_pkg::point_t l_in, r_in;

  logic             out_valid_r;
  tcfp_pkg::point_t out_pt_r;
  logic             out_last_r, out_ovf_r;

  logic             out_free, emit, emit_last, load_prod;
  tcfp_pkg::point_t emit_pt;
  logic [1:0]       c0, c1;
  logic             straight;

  // Walk decisions.
  logic             l_tight, l_ok, restart_r, r_tight, r_ok, restart_l;
  tcfp_pkg::point_t lcur;
  cnt_t             licur, i_next;
  tcfp_pkg::point_t apex_nxt, lft_nxt, rgt_nxt;
  cnt_t             ai_nxt, li_nxt, ri_nxt;

  assign cur_pts[0] = cur_r.p0;
  assign cur_pts[1] = cur_r.p1;
  assign cur_pts[2] = cur_r.p2;
  assign c0 = (cur_r.u == 2'd0) ? 2'd1 : 2'd0;
  assign c1 = (cur_r.u == 2'd2) ? 2'd1 : 2'd2;

  assign out_free = !out_valid_r || out_ch.ready;
  assign l_in = (i_r == cur_r.n) ? end_pt : rd_l_r;
  assign r_in = (i_r == cur_r.n) ? end_pt : rd_r_r;

  // Operands of the five cross products. While a portal is being oriented only
  // the first slot is meaningful.
  always_comb begin
    if (state_r == tcfp_pkg::ST_PROD) begin
      op_a = prev_pts_r[cur_r.u];
      for (int k = 0; k < tcfp_pkg::NUM_CROSS; k++) begin
        op_b[k] = prev_pts_r[c0];
        op_c[k] = prev_pts_r[c1];
      end
    end else begin
      op_a = apex_r;
      op_b[0] = l_in;  op_c[0] = lft_r;
      op_b[1] = l_in;  op_c[1] = rgt_r;
      op_b[2] = r_in;  op_c[2] = rgt_r;
      op_b[3] = r_in;  op_c[3] = lft_r;
      op_b[4] = r_in;  op_c[4] = l_in;
    end
  end

  always_comb begin
    for (int k = 0; k < tcfp_pkg::NUM_CROSS; k++) begin
      cr[k] = tcfp_pkg::CROSS_W'(pa_r[k]) - tcfp_pkg::CROSS_W'(pb_r[k]);
    end
  end

  // One funnel step, from the crosses of portal i against the current funnel.
  always_comb begin
    l_tight   = (cr[0] >= 0);
    l_ok      = (apex_r == lft_r) || (apex_r == rgt_r) || (cr[1] <= 0);
    restart_r = l_tight && !l_ok;
    lcur      = l_tight ? lpt_r : lft_r;
    licur     = l_tight ? i_r : li_r;
    r_tight   = !restart_r && (cr[2] <= 0);
    r_ok      = (apex_r == rgt_r) || (apex_r == lcur) ||
                ((l_tight ? cr[4] : cr[3]) >= 0);
    restart_l = r_tight && !r_ok;

    apex_nxt = apex_r;  ai_nxt = ai_r;
    lft_nxt  = lft_r;   li_nxt = li_r;
    rgt_nxt  = rgt_r;   ri_nxt = ri_r;
    i_next   = i_r + 1'b1;
    if (restart_r) begin
      apex_nxt = rgt_r;  ai_nxt = ri_r;
      lft_nxt  = rgt_r;  li_nxt = ri_r;
      i_next   = ri_r + 1'b1;
    end else begin
      lft_nxt = lcur;
      li_nxt  = licur;
      if (restart_l) begin
        apex_nxt = lcur;  ai_nxt = licur;
        rgt_nxt  = lcur;  ri_nxt = licur;
        i_next   = licur + 1'b1;
      end else if (r_tight) begin
        rgt_nxt = rpt_r;
        ri_nxt  = i_r;
      end
    end
  end

  assign straight = (cur_r.idx == cnt_t'(1)) ? !(cr[0] > 0) :
                    ((cur_r.e0_id == last_l_id_r) || (cur_r.e1_id == last_r_id_r));

  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_pt   = start_pt;
    load_prod = 1'b0;
    unique case (state_r)
      tcfp_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_nxt = tcfp_pkg::ST_PROD;
      end
      tcfp_pkg::ST_PROD: begin
        load_prod = 1'b1;
        state_nxt = tcfp_pkg::ST_STORE;
      end
      tcfp_pkg::ST_STORE: begin
        state_nxt = cur_r.last ? tcfp_pkg::ST_START : tcfp_pkg::ST_IDLE;
      end
      tcfp_pkg::ST_START: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = tcfp_pkg::ST_READ;
        end
      end
      tcfp_pkg::ST_READ: begin
        state_nxt = tcfp_pkg::ST_MUL;
      end
      tcfp_pkg::ST_MUL: begin
        load_prod = 1'b1;
        state_nxt = tcfp_pkg::ST_DEC;
      end
      tcfp_pkg::ST_DEC: begin
        if (out_free) begin
          emit      = (restart_r || restart_l) && (cnt_r < MAXC);
          emit_pt   = restart_r ? rgt_r : lcur;
          state_nxt = (i_next > cur_r.n) ? tcfp_pkg::ST_END : tcfp_pkg::ST_READ;
        end
      end
      tcfp_pkg::ST_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_pt   = end_pt;
          state_nxt = tcfp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcfp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && !out_ch.ready) || emit;
    end
  end

  always_ff @(posedge clk) begin
    rd_l_r <= mem_l[i_r[AW-1:0]];
    rd_r_r <= mem_r[i_r[AW-1:0]];
    if (state_r == tcfp_pkg::ST_STORE && cur_r.kind == tcfp_pkg::KIND_PORTAL) begin
      mem_l[cur_r.idx[AW-1:0]] <= straight ? prev_pts_r[c0] : prev_pts_r[c1];
      mem_r[cur_r.idx[AW-1:0]] <= straight ? prev_pts_r[c1] : prev_pts_r[c0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tcfp_pkg::ST_IDLE && pop_valid) cur_r <= pop_item;

    if (load_prod) begin
      for (int k = 0; k < tcfp_pkg::NUM_CROSS; k++) begin
        pa_r[k] <= ((tcfp_pkg::COORD_W+1)'(op_b[k].x) - (tcfp_pkg::COORD_W+1)'(op_a.x)) *
                   ((tcfp_pkg::COORD_W+1)'(op_c[k].y) - (tcfp_pkg::COORD_W+1)'(op_a.y));
        pb_r[k] <= ((tcfp_pkg::COORD_W+1)'(op_b[k].y) - (tcfp_pkg::COORD_W+1)'(op_a.y)) *
                   ((tcfp_pkg::COORD_W+1)'(op_c[k].x) - (tcfp_pkg::COORD_W+1)'(op_a.x));
      end
      lpt_r <= l_in;
      rpt_r <= r_in;
    end

    if (state_r == tcfp_pkg::ST_STORE) begin
      if (cur_r.kind == tcfp_pkg::KIND_PORTAL) begin
        last_l_id_r <= straight ? cur_r.e0_id : cur_r.e1_id;
        last_r_id_r <= straight ? cur_r.e1_id : cur_r.e0_id;
      end
      if (cur_r.kind != tcfp_pkg::KIND_DROP) begin
        for (int c = 0; c < 3; c++) prev_pts_r[c] <= cur_pts[c];
      end
    end

    if (state_r == tcfp_pkg::ST_START && out_free) begin
      apex_r <= start_pt;
      lft_r  <= start_pt;
      rgt_r  <= start_pt;
      ai_r   <= '0;
      li_r   <= '0;
      ri_r   <= '0;
      i_r    <= cnt_t'(1);
      cnt_r  <= cnt_t'(1);
    end else if (state_r == tcfp_pkg::ST_DEC && out_free) begin
      apex_r <= apex_nxt;
      lft_r  <= lft_nxt;
      rgt_r  <= rgt_nxt;
      ai_r   <= ai_nxt;
      li_r   <= li_nxt;
      ri_r   <= ri_nxt;
      i_r    <= i_next;
      if (emit) cnt_r <= cnt_r + 1'b1;
    end

    if (emit) begin
      out_pt_r   <= emit_pt;
      out_last_r <= emit_last;
      out_ovf_r  <= cur_r.ovf;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.waypoint_x = out_pt_r.x;
  assign out_ch.waypoint_y = out_pt_r.y;
  assign out_ch.last_point = out_last_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

// File: sv/triangle_channel_funnel_path.sv
// Funnel path planner over a channel of adjacent triangles.
// Input channel (in_ch): one word per triangle, three vertex ids and three
// signed Q15.8 corners; last_triangle closes the channel and starts the path.
// Result channel (out_ch): the path as a run of words, the start point, every
// apex where the path turns, then the end point with last_point set. Every
// word of a path carries overflow when more than MAX_TRIANGLES triangles came in.
// Configuration (cfg_*): start and end point, written while the block is idle.
// A small front classifies each word against the previous triangle and hands
// it through a two-entry queue to the back, which builds portals and walks.
// The back handles one triangle at a time, through ST_IDLE, ST_PROD and ST_STORE;
// the queue takes further words meanwhile until it is full. After the last
// triangle the walk visits each portal through ST_READ, ST_MUL and ST_DEC, for the
// portal memory read and the registered cross-product multipliers; a funnel
// restart revisits portals. With the back idle, the start point is registered
// after the last triangle passes the queue, ST_PROD, ST_STORE and ST_START.
// Reset clears the control state and the configuration registers; the
// portal memory is not cleared. When the receiver stalls, the output
// register holds its word and the walk waits; the queue takes input until full.
module triangle_channel_funnel_path #(
  parameter int MAX_TRIANGLES  = 32,
  parameter int VERTEX_ID_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tcfp_in_if.sink                            in_ch,
  tcfp_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcfp_pkg::COORD_W-1:0]       cfg_data
);

  tcfp_pkg::coord_t start_x_r, start_y_r, end_x_r, end_y_r;
  tcfp_pkg::point_t start_pt, end_pt;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  tcfp_pkg::item_t push_item, pop_item;

  // Configuration registers, reset to the origin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
    end else if (cfg_we) begin
      unique case (tcfp_pkg::cfg_idx_t'(cfg_index))
        tcfp_pkg::CFG_START_X: start_x_r <= cfg_data;
        tcfp_pkg::CFG_START_Y: start_y_r <= cfg_data;
        tcfp_pkg::CFG_END_X:   end_x_r   <= cfg_data;
        tcfp_pkg::CFG_END_Y:   end_y_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign start_pt = '{x: start_x_r, y: start_y_r};
  assign end_pt   = '{x: end_x_r, y: end_y_r};

  tcfp_front #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .VERTEX_ID_BITS(VERTEX_ID_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_item (push_item),
    .push_ready(push_ready)
  );

  tcfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_item (push_item),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready)
  );

  tcfp_back #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_item (pop_item),
    .pop_ready(pop_ready),
    .start_pt (start_pt),
    .end_pt   (end_pt),
    .out_ch   (out_ch)
  );

endmodule

// File: sv/tcfp_checker.sv
`include "triangle_channel_funnel_path_assert.svh"

module tcfp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tcfp_pkg::COORD_W-1:0]   out_x,
  input logic [tcfp_pkg::COORD_W-1:0]   out_y,
  input logic                           out_last
);

  // A stalled result word keeps its point.
  `TCFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_last), "stalled result word changed")

  // After the end point of a path is taken, no word follows at once.
  `TCFP_ASSERT_NEXT(a_gap_after_end, out_valid && out_ready && out_last, !out_valid, "word right after end point")

  // Reset empties the output register.
  `TCFP_ASSERT_NEXT_ALWAYS(a_reset_out, !rst_n, !out_valid, "result valid after reset")

  // Reset empties the queue, so the input is open right after it.
  `TCFP_ASSERT_NEXT_ALWAYS(a_reset_in, !rst_n, in_ready, "input closed after reset")

endmodule

bind triangle_channel_funnel_path tcfp_checker u_tcfp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_x    (out_ch.waypoint_x),
  .out_y    (out_ch.waypoint_y),
  .out_last (out_ch.last_point)
);
